/* hdl/cht_pkg.sv */
// shared types, constants and the bucket hash for the chained hash table unit
// no dependencies; imported by cht_node_store and chained_hash_table_unit

package cht_pkg;

    // table geometry (bucket count is a power of two: the hash keeps low bits)
    localparam int BUCKETS = 16;
    localparam int NODES   = 64;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NIDX_W  = $clog2(NODES);
    localparam int PTR_W   = $clog2(NODES + 1);
    localparam int KEY_W   = 31;
    localparam int VAL_W   = 64;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 3;

    // empty link marker
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // result codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  payload;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
    } t_out_item;

    // key and payload of one node
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] payload;
    } t_node_data;

    // access request to the node store
    typedef struct packed {
        logic              rd_en;
        logic [NIDX_W-1:0] rd_addr;
        logic              data_we;
        logic [NIDX_W-1:0] data_addr;
        t_node_data        data_val;
        logic              link_we;
        logic [NIDX_W-1:0] link_addr;
        t_ptr              link_val;
    } t_node_req;

    // registered read data from the node store
    typedef struct packed {
        t_node_data data;
        t_ptr       link;
    } t_node_rd;

    // bucket = (3*key + 5) mod BUCKETS
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        logic [KEY_W+1:0] h;
        h = {2'b00, key} + {1'b0, key, 1'b0} + (KEY_W+2)'(5);
        return h[BKT_W-1:0];
    endfunction

endpackage

/* hdl/chained_hash_table_unit.sv */
// hash table with separate chaining over a fixed node pool, plus free list
// depends on cht_pkg and cht_node_store
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready| o_out_item (t_out_item)
//
// one transaction is worked at a time; the node store's one read port sets the pace.
// insert goes from idle to emit, through pop when a freed node is reused; search walks the chain,
// delete walks it and then unlinks; mode three and an empty bucket go straight to emit.
// a chain walk is bounded at NODES node reads.
// reset clears the bucket head valid bits, free list and fresh count; no clearing pass.
// a result waiting on the output register holds the next result, and intake with it.

module chained_hash_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cht_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cht_pkg::t_out_item o_out_item
);
    import cht_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POP    = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_UNLINK = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    // control registers
    logic [2:0]        r_state, n_state;
    t_ptr              r_free_head, n_free_head;
    t_ptr              r_fresh, n_fresh;
    logic              r_out_valid, n_out_valid;
    logic [BUCKETS-1:0] r_bvalid;

    // transaction context
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_payload, n_payload;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    t_ptr              r_head, n_head;
    t_ptr              r_cur, n_cur;
    t_ptr              r_prev, n_prev;
    logic [NIDX_W-1:0] r_steps, n_steps;
    t_out_item         r_res, n_res;
    t_out_item         r_out, n_out;

    // bucket heads
    t_ptr              r_bhead [BUCKETS];
    logic              bh_we;
    logic [BKT_W-1:0]  bh_addr;
    t_ptr              bh_val;

    logic              in_fire;
    logic [BKT_W-1:0]  in_bkt;
    t_ptr              in_head;
    t_node_req         node_req;
    t_node_rd          node_rd;

    cht_node_store u_store (
        .i_clk (i_clk),
        .i_req (node_req),
        .o_rd  (node_rd)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign in_bkt      = bucket_of(i_in_item.key);
    assign in_head     = r_bvalid[in_bkt] ? r_bhead[in_bkt] : NIL;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // sequencer: next state, memory requests, bucket head updates
    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_mode      = r_mode;
        n_key       = r_key;
        n_payload   = r_payload;
        n_bkt       = r_bkt;
        n_head      = r_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        bh_we       = 1'b0;
        bh_addr     = r_bkt;
        bh_val      = NIL;
        node_req    = '0;

        // output register drains independently
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_mode    = i_in_item.mode;
                    n_key     = i_in_item.key;
                    n_payload = i_in_item.payload;
                    n_bkt     = in_bkt;
                    n_head    = in_head;
                    n_res     = '{status: ST_MISSING, found_value: '0};
                    n_state   = S_EMIT;
                    case (i_in_item.mode)
                        MODE_INSERT: begin
                            if (r_free_head != NIL) begin
                                // reuse a freed node: fetch its link first
                                node_req.rd_en   = 1'b1;
                                node_req.rd_addr = r_free_head[NIDX_W-1:0];
                                n_cur            = r_free_head;
                                n_state          = S_POP;
                            end else if (r_fresh != PTR_W'(NODES)) begin
                                // take the next never-used node
                                node_req.data_we   = 1'b1;
                                node_req.data_addr = r_fresh[NIDX_W-1:0];
                                node_req.data_val  = '{key: i_in_item.key,
                                                       payload: i_in_item.payload};
                                node_req.link_we   = 1'b1;
                                node_req.link_addr = r_fresh[NIDX_W-1:0];
                                node_req.link_val  = in_head;
                                bh_we              = 1'b1;
                                bh_addr            = in_bkt;
                                bh_val             = r_fresh;
                                n_fresh            = r_fresh + PTR_W'(1);
                                n_res.status       = ST_INSERTED;
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        MODE_SEARCH, MODE_DELETE: begin
                            if (in_head != NIL) begin
                                node_req.rd_en   = 1'b1;
                                node_req.rd_addr = in_head[NIDX_W-1:0];
                                n_cur            = in_head;
                                n_prev           = NIL;
                                n_steps          = '0;
                                n_state          = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            // link of the reused node becomes the new free head
            S_POP: begin
                n_free_head        = node_rd.link;
                node_req.data_we   = 1'b1;
                node_req.data_addr = r_cur[NIDX_W-1:0];
                node_req.data_val  = '{key: r_key, payload: r_payload};
                node_req.link_we   = 1'b1;
                node_req.link_addr = r_cur[NIDX_W-1:0];
                node_req.link_val  = r_head;
                bh_we              = 1'b1;
                bh_addr            = r_bkt;
                bh_val             = r_cur;
                n_res.status       = ST_INSERTED;
                n_state            = S_EMIT;
            end

            // compare one chain node per read
            S_WALK: begin
                if (node_rd.data.key == r_key) begin
                    if (r_mode == MODE_SEARCH) begin
                        n_res   = '{status: ST_FOUND, found_value: node_rd.data.payload};
                        n_state = S_EMIT;
                    end else begin
                        if (r_prev == NIL) begin
                            bh_we   = 1'b1;
                            bh_addr = r_bkt;
                            bh_val  = node_rd.link;
                        end else begin
                            node_req.link_we   = 1'b1;
                            node_req.link_addr = r_prev[NIDX_W-1:0];
                            node_req.link_val  = node_rd.link;
                        end
                        n_state = S_UNLINK;
                    end
                end else if (node_rd.link == NIL ||
                             r_steps == NIDX_W'(NODES - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    node_req.rd_en   = 1'b1;
                    node_req.rd_addr = node_rd.link[NIDX_W-1:0];
                    n_prev           = r_cur;
                    n_cur            = node_rd.link;
                    n_steps          = r_steps + NIDX_W'(1);
                end
            end

            // push the removed node onto the free list
            S_UNLINK: begin
                node_req.link_we   = 1'b1;
                node_req.link_addr = r_cur[NIDX_W-1:0];
                node_req.link_val  = r_free_head;
                n_free_head        = r_cur;
                n_res.status       = ST_DELETED;
                n_state            = S_EMIT;
            end

            // hand the result to the output register once it is free
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
            r_bvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            if (bh_we) begin
                r_bvalid[bh_addr] <= 1'b1;
            end
        end
    end

    // payload and context registers
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_payload <= n_payload;
        r_bkt     <= n_bkt;
        r_head    <= n_head;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_steps   <= n_steps;
        r_res     <= n_res;
        r_out     <= n_out;
        if (bh_we) begin
            r_bhead[bh_addr] <= bh_val;
        end
    end

endmodule

/* hdl/cht_node_store.sv */
// node pool storage: key/payload array and link array, one shared read port
// depends on cht_pkg

module cht_node_store (
    input  logic              i_clk,
    input  cht_pkg::t_node_req i_req,
    output cht_pkg::t_node_rd  o_rd
);
    import cht_pkg::*;

    t_node_data r_data_mem [NODES];
    t_ptr       r_link_mem [NODES];
    t_node_rd   r_rd;

    // key and payload write port
    always_ff @(posedge i_clk) begin
        if (i_req.data_we) begin
            r_data_mem[i_req.data_addr] <= i_req.data_val;
        end
    end

    // link write port
    always_ff @(posedge i_clk) begin
        if (i_req.link_we) begin
            r_link_mem[i_req.link_addr] <= i_req.link_val;
        end
    end

    // registered read, both arrays at one address
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd.data <= r_data_mem[i_req.rd_addr];
            r_rd.link <= r_link_mem[i_req.rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

/* tb/chained_hash_table_unit_test.sv */
`timescale 1ns / 1ps
// testbench for chained_hash_table_unit: directed and random insert, search and delete traffic
// depends on cht_pkg and the chained_hash_table_unit rtl; self-checking against its own table

module chained_hash_table_unit_test;
    import cht_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * NODES + 16;
    localparam int FILL_ITEMS   = 250;
    localparam int EMPTY_ITEMS  = 160;
    localparam int KEY_POOL     = 24;

    localparam logic [KEY_W-1:0]  KEY_MAX     = '1;
    localparam logic [VAL_W-1:0]  VAL_MAX     = '1;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // shadow copy of the table; predicts one reply per request
    class hash_table_tracker;
        t_ptr             bucket_head[BUCKETS];
        logic [KEY_W-1:0] node_key[NODES];
        logic [VAL_W-1:0] node_payload[NODES];
        t_ptr             node_link[NODES];
        t_ptr             free_head;
        int unsigned      fresh_count;
        t_out_item        pending_replies[$];
        int unsigned      errors;

        function new();
            foreach (bucket_head[i]) bucket_head[i] = NIL;
            foreach (node_link[i]) node_link[i] = NIL;
            free_head   = NIL;
            fresh_count = 0;
            errors      = 0;
        endfunction

        // chain index: (3*key + 5) mod BUCKETS
        function logic [BKT_W-1:0] chain_of(logic [KEY_W-1:0] key);
            logic [KEY_W+1:0] h;
            h = (KEY_W+2)'(key) * 3 + 5;
            return BKT_W'(h % BUCKETS);
        endfunction

        function t_out_item apply_op(t_in_item op);
            t_out_item        r;
            logic [BKT_W-1:0] b;
            t_ptr             n;
            t_ptr             prev;
            t_ptr             cur;
            int               steps;
            r.status      = ST_MISSING;
            r.found_value = '0;
            b = chain_of(op.key);
            case (op.mode)
                MODE_INSERT: begin
                    // freed nodes first, then never-used ones
                    n = NIL;
                    if (free_head < NODES) begin
                        n = free_head;
                        free_head = node_link[n];
                    end else if (fresh_count < NODES) begin
                        n = t_ptr'(fresh_count);
                        fresh_count++;
                    end
                    if (n < NODES) begin
                        node_key[n]     = op.key;
                        node_payload[n] = op.payload;
                        node_link[n]    = bucket_head[b];
                        bucket_head[b]  = n;
                        r.status = ST_INSERTED;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                MODE_SEARCH, MODE_DELETE: begin
                    prev  = NIL;
                    cur   = bucket_head[b];
                    steps = 0;
                    while (cur < NODES && steps < NODES && node_key[cur] != op.key) begin
                        prev = cur;
                        cur  = node_link[cur];
                        steps++;
                    end
                    if (cur < NODES && steps < NODES) begin
                        if (op.mode == MODE_SEARCH) begin
                            r.status      = ST_FOUND;
                            r.found_value = node_payload[cur];
                        end else begin
                            // unlink and push onto the free list
                            if (prev < NODES) node_link[prev] = node_link[cur];
                            else bucket_head[b] = node_link[cur];
                            node_link[cur] = free_head;
                            free_head      = cur;
                            r.status       = ST_DELETED;
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(t_in_item op);
            pending_replies.push_back(apply_op(op));
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply status=%0d found_value=%h",
                         $time, got.status, got.found_value);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.found_value !== want.found_value) begin
                $display("%0t: found_value mismatch expected=%h actual=%h",
                         $time, want.found_value, got.found_value);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_ready  = 1'b1;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      quiet_cycles   = 0;
    logic [KEY_W-1:0] key_pool[KEY_POOL];

    hash_table_tracker tracker = new();

    chained_hash_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // push one request transaction, with random gaps ahead of it
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] payload);
        t_in_item op;
        op.mode    = mode;
        op.key     = key;
        op.payload = payload;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= op;
        do @(posedge i_clk); while (!in_ready);
        tracker.note_request(op);
    endtask

    // keys mostly from a small pool so searches and deletes hit, some fully random
    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(9) == 0) return r[KEY_W-1:0];
        return key_pool[$urandom_range(KEY_POOL-1)];
    endfunction

    task automatic random_request(input int ins_w, input int srch_w, input int del_w);
        int               pick;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(99);
        if (pick < ins_w) mode = MODE_INSERT;
        else if (pick < ins_w + srch_w) mode = MODE_SEARCH;
        else if (pick < ins_w + srch_w + del_w) mode = MODE_DELETE;
        else mode = MODE_UNUSED;
        send_request(mode, pick_key(), {$urandom, $urandom});
    endtask

    // one idling setting: fill the pool past full, then drain it
    task automatic run_phase(input int send_pct, input int recv_pct);
        logic [31:0] r;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        foreach (key_pool[i]) begin
            r = $urandom;
            key_pool[i] = (i % 2 == 0) ? KEY_W'($urandom_range(63)) : r[KEY_W-1:0];
        end
        repeat (FILL_ITEMS) random_request(60, 25, 10);
        repeat (EMPTY_ITEMS) random_request(20, 30, 45);
    endtask

    // reply side: check each accepted transaction, stall at random
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_valid === 1'b1 && out_ready) tracker.check_reply(out_item);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("chained_hash_table_unit verification failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, unused mode, extremes of key and payload
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_DELETE, KEY_MAX, VAL_MAX);
        send_request(MODE_UNUSED, KEY_MAX, VAL_MAX);
        send_request(MODE_INSERT, '0, '0);
        send_request(MODE_INSERT, KEY_MAX, VAL_MAX);
        send_request(MODE_SEARCH, '0, VAL_MAX);
        send_request(MODE_SEARCH, KEY_MAX, '0);
        // duplicate key shadows the older entry until deleted
        send_request(MODE_INSERT, '0, 64'h0123_4567_89ab_cdef);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_DELETE, '0, '0);
        send_request(MODE_SEARCH, '0, '0);
        // keys 0, 16, 32, 48 and 64 share one chain: unlink middle, then tail
        send_request(MODE_INSERT, 31'd16, 64'haaaa_5555_aaaa_5555);
        send_request(MODE_INSERT, 31'd32, 64'h5555_aaaa_5555_aaaa);
        send_request(MODE_DELETE, 31'd16, '0);
        send_request(MODE_SEARCH, 31'd32, '0);
        send_request(MODE_SEARCH, 31'd16, '0);
        send_request(MODE_DELETE, '0, '0);
        // inserts that reuse freed nodes
        send_request(MODE_INSERT, 31'd48, 64'hfeed_face_dead_beef);
        send_request(MODE_INSERT, 31'd16, 64'h8000_0000_0000_0001);
        send_request(MODE_SEARCH, 31'd48, '0);
        send_request(MODE_DELETE, 31'd48, '0);
        send_request(MODE_DELETE, 31'd64, '0);
        send_request(MODE_UNUSED, '0, '0);

        // random traffic under each idling setting
        run_phase(0, 0);
        run_phase(47, 0);
        run_phase(0, 47);
        run_phase(24, 24);
        in_valid <= 1'b0;

        // drain outstanding replies, then watch for stray ones
        while (tracker.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
            $display("chained_hash_table_unit verification clean");
        end else begin
            $display("chained_hash_table_unit verification failed");
        end
        $finish;
    end

endmodule
